// File: rtl/core/cctm_pkg.sv
package cctm_pkg;

    localparam int BinCountDefault    = 2048;
    localparam int OctaveCountDefault = 8;
    localparam int MagW   = 24;
    localparam int SumW   = 32;
    localparam int ScoreW = 34;
    localparam int RateW  = 18;
    localparam logic [RateW-1:0] RateReset = 18'd44100;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [MagW-1:0] magnitude;
        logic            last_bin;
    } in_beat_t;

    typedef struct packed {
        logic              chord_found;
        logic [3:0]        root_note;
        logic [1:0]        chord_quality;
        logic [ScoreW-1:0] best_score;
    } out_beat_t;

    typedef enum logic [1:0] {
        QUAL_MAJOR = 2'd0,
        QUAL_MINOR = 2'd1,
        QUAL_MAJ7  = 2'd2
    } quality_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCORE = 2'd1,
        BK_DONE  = 2'd2
    } back_state_t;

    // One queued job: a peak to place into a pitch class, or the end of a frame.
    typedef struct packed {
        logic            is_last;
        logic            is_peak;
        logic [12:0]     idx;
        logic [MagW-1:0] mag;
    } job_t;

    function automatic logic [15:0] note_hz100(input logic [3:0] n);
        case (n)
            4'd0:    return 16'd1635;
            4'd1:    return 16'd1732;
            4'd2:    return 16'd1835;
            4'd3:    return 16'd1945;
            4'd4:    return 16'd2060;
            4'd5:    return 16'd2183;
            4'd6:    return 16'd2312;
            4'd7:    return 16'd2450;
            4'd8:    return 16'd2596;
            4'd9:    return 16'd2750;
            4'd10:   return 16'd2914;
            4'd11:   return 16'd3087;
            default: return 16'd0;
        endcase
    endfunction

    // Doubled boundary products, wrapping across octaves at C and B.
    function automatic logic [33:0] lower2(input logic [3:0] n);
        if (n == 4'd0)
            return {2'b0, 32'(note_hz100(4'd0)) * 32'(note_hz100(4'd11))};
        return {1'b0, 32'(note_hz100(n)) * 32'(note_hz100(n - 4'd1)), 1'b0};
    endfunction

    function automatic logic [33:0] upper2(input logic [3:0] n);
        if (n == 4'd11)
            return {32'(note_hz100(4'd11)) * 32'(note_hz100(4'd0)), 2'b0};
        return {1'b0, 32'(note_hz100(n)) * 32'(note_hz100(n + 4'd1)), 1'b0};
    endfunction

    function automatic logic [3:0] tmpl_iv(input logic [1:0] t, input logic [1:0] k);
        case (k)
            2'd0:    return 4'd0;
            2'd1:    return (t == QUAL_MINOR) ? 4'd3 : 4'd4;
            2'd2:    return 4'd7;
            default: return (t == QUAL_MAJ7) ? 4'd11 : 4'd0;
        endcase
    endfunction

endpackage

// File: rtl/core/cctm_front.sv
module cctm_front
    import cctm_pkg::*;
#(
    parameter int BIN_COUNT = BinCountDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_beat_t beat,
    output logic     push,
    output job_t     job
);

    localparam int IdxW = $clog2(BIN_COUNT);

    logic [MagW-1:0] older_reg, center_reg;
    logic [IdxW-1:0] count_reg;
    logic            peak;

    assign peak = (count_reg >= IdxW'(2)) && (center_reg > older_reg)
                  && (center_reg > beat.magnitude);

    always_comb
    begin
        job.is_last = beat.last_bin;
        job.is_peak = peak;
        job.idx     = 13'(count_reg - IdxW'(1));
        job.mag     = center_reg;
    end
    assign push = take && (peak || beat.last_bin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            center_reg <= '0;
            count_reg  <= '0;
        end
        else if (take)
        begin
            if (beat.last_bin)
            begin
                older_reg  <= '0;
                center_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                older_reg  <= center_reg;
                center_reg <= beat.magnitude;
                if (count_reg < IdxW'(BIN_COUNT - 1))
                    count_reg <= count_reg + IdxW'(1);
            end
        end
    end

endmodule

// File: rtl/core/cctm_queue.sv
module cctm_queue
    import cctm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic empty,
    output logic almost_full,
    output job_t head
);

    localparam int PtrW = $clog2(QueueDepth);

    job_t          mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0]   cnt_reg;

    assign empty       = (cnt_reg == '0);
    assign almost_full = (cnt_reg >= (PtrW+1)'(QueueDepth - 1));
    assign head        = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + PtrW'(1);
            if (pop)
                rd_reg <= rd_reg + PtrW'(1);
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

endmodule

// File: rtl/core/cctm_back.sv
module cctm_back
    import cctm_pkg::*;
#(
    parameter int BIN_COUNT   = BinCountDefault,
    parameter int OCTAVE_COUNT = OctaveCountDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RateW-1:0] sample_rate,
    input  logic             empty,
    input  job_t             head,
    output logic             pop,
    output logic             idle,
    output logic             result_valid,
    output out_beat_t        result
);

    localparam int Log2Bins = $clog2(2 * BIN_COUNT);
    // fq fits 13+18+6-12 bits; lhs = 20000*fq^2 compared against products << (12+2*o).
    localparam int FqW  = 26;
    localparam int SqW  = 52;
    localparam int LhsW = 90;

    back_state_t state_reg, state_next;

    // Peak pipeline: stage 1 frequency, stage 2 square, stage 3 scale by 20000; its output is classified and added.
    logic            v1_reg, v2_reg, v3_reg;
    logic [MagW-1:0] m1_reg, m2_reg, m3_reg;
    logic [FqW-1:0]  fq1_reg;
    logic [SqW-1:0]  sq2_reg;
    logic [LhsW-1:0] lhs3_reg;
    logic [37:0]     prod;

    logic [SumW-1:0] sums_reg [12];
    logic [3:0]      root_reg;
    logic [1:0]      tq_reg, tk_reg;
    logic [ScoreW-1:0] acc_reg, best_reg;
    logic [3:0]      best_root_reg;
    logic [1:0]      best_q_reg;

    logic            hit;
    logic [3:0]      hit_class;
    logic [4:0]      pc_sum;
    logic [3:0]      pc;
    logic [1:0]      tlen_last;
    logic [ScoreW-1:0] acc_new;
    logic            pipe_busy;
    logic            stripped_reg;

    assign pipe_busy = v1_reg || v2_reg || v3_reg;
    assign prod = {7'b0, head.idx, 6'b0} * {20'b0, sample_rate};

    always_comb
    begin
        hit = 1'b0;
        hit_class = '0;
        for (int o = OCTAVE_COUNT - 1; o >= 0; o--)
        begin
            for (int n = 11; n >= 0; n--)
            begin
                if ((lhs3_reg > (LhsW'(lower2(4'(n))) << (12 + 2 * o)))
                    && (lhs3_reg <= (LhsW'(upper2(4'(n))) << (12 + 2 * o))))
                begin
                    hit = 1'b1;
                    hit_class = 4'(n);
                end
            end
        end
    end

    assign pc_sum    = {1'b0, root_reg} + {1'b0, tmpl_iv(tq_reg, tk_reg)};
    assign pc        = (pc_sum >= 5'd12) ? 4'(pc_sum - 5'd12) : pc_sum[3:0];
    assign tlen_last = (tq_reg == QUAL_MAJ7) ? 2'd3 : 2'd2;
    assign acc_new   = acc_reg + ScoreW'(sums_reg[pc]);

    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    if (head.is_peak && !head.is_last)
                        pop = 1'b1;
                    else if (!pipe_busy)
                    begin
                        if (head.is_peak && !stripped_reg)
                            pop = 1'b0;
                        else
                        begin
                            pop = 1'b1;
                            state_next = BK_SCORE;
                        end
                    end
                end
            end
            BK_SCORE:
            begin
                if (root_reg == 4'd11 && tq_reg == QUAL_MAJ7 && tk_reg == tlen_last)
                    state_next = BK_DONE;
            end
            BK_DONE:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // A last bin that is also a peak: its peak part goes first, then the job
    // comes back as a plain end of frame.
    logic strip_peak;
    assign strip_peak = (state_reg == BK_IDLE) && !empty && head.is_peak && head.is_last
                        && !pipe_busy && !stripped_reg;

    assign idle = (state_reg == BK_IDLE) && !pipe_busy;
    assign result_valid = (state_reg == BK_DONE);
    always_comb
    begin
        result.chord_found   = (best_reg != '0);
        result.root_note     = best_root_reg;
        result.chord_quality = best_q_reg;
        result.best_score    = best_reg;
    end

    logic peak_issue;
    assign peak_issue = (pop && head.is_peak && !head.is_last) || strip_peak;

    always_ff @(posedge clk)
    begin
        m1_reg   <= head.mag;
        fq1_reg  <= FqW'(prod >> Log2Bins);
        m2_reg   <= m1_reg;
        sq2_reg  <= SqW'(fq1_reg) * SqW'(fq1_reg);
        m3_reg   <= m2_reg;
        lhs3_reg <= LhsW'(sq2_reg) * LhsW'(20000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            stripped_reg <= 1'b0;
            for (int i = 0; i < 12; i++)
                sums_reg[i] <= '0;
            root_reg <= '0;
            tq_reg <= '0;
            tk_reg <= '0;
            acc_reg <= '0;
            best_reg <= '0;
            best_root_reg <= '0;
            best_q_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg <= peak_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (pop)
                stripped_reg <= 1'b0;
            else if (strip_peak)
                stripped_reg <= 1'b1;
            if (v3_reg && hit)
                sums_reg[hit_class] <= (SumW + 1)'({1'b0, sums_reg[hit_class]}
                    + (SumW + 1)'(m3_reg)) > (SumW + 1)'(33'hFFFFFFFF)
                    ? '1 : sums_reg[hit_class] + SumW'(m3_reg);
            if (state_reg == BK_IDLE && state_next == BK_SCORE)
            begin
                root_reg <= '0;
                tq_reg <= '0;
                tk_reg <= '0;
                acc_reg <= '0;
                best_reg <= '0;
                best_root_reg <= '0;
                best_q_reg <= '0;
            end
            else if (state_reg == BK_SCORE)
            begin
                if (tk_reg == tlen_last)
                begin
                    acc_reg <= '0;
                    tk_reg <= '0;
                    if (acc_new > best_reg)
                    begin
                        best_reg <= acc_new;
                        best_root_reg <= root_reg;
                        best_q_reg <= tq_reg;
                    end
                    if (tq_reg == QUAL_MAJ7)
                    begin
                        tq_reg <= QUAL_MAJOR;
                        root_reg <= root_reg + 4'd1;
                    end
                    else
                        tq_reg <= tq_reg + 2'd1;
                end
                else
                begin
                    acc_reg <= acc_new;
                    tk_reg <= tk_reg + 2'd1;
                end
            end
            else if (state_reg == BK_DONE)
            begin
                for (int i = 0; i < 12; i++)
                    sums_reg[i] <= '0;
            end
        end
    end

endmodule

// File: rtl/core/chroma_chord_template_match.sv
// Pitch-class chord matcher for one spectrum frame.
// Input: pulse start with in_beat (magnitude, last_bin) while busy is low;
// one beat per bin, bin 0 first. A strict local peak goes through a
// three-stage frequency pipeline and is added, saturating, to one of 12
// pitch-class sums.
// Configuration: cfg_we with cfg_wdata writes sample_rate; write only
// while the block is idle. Reset value is 44100 Hz.
// Output: one beat on done with result, only for a beat marked last_bin.
// Scoring walks 12 roots by 3 templates, one sum term per cycle. Scoring
// starts once the peak pipeline has drained, also of a peak in the bin
// before the last; done rises when scoring ends, and the frame state then
// clears. Bins are taken one per cycle while busy is low; busy rises when
// the job queue holds three jobs or from a frame end until its result is
// out.
// Reset clears all frame state and the queue. The receiver cannot stall:
// done lasts one cycle and is not repeated.
module chroma_chord_template_match
    import cctm_pkg::*;
#(
    parameter int BIN_COUNT    = BinCountDefault,
    parameter int OCTAVE_COUNT = OctaveCountDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  in_beat_t         in_beat,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [RateW-1:0] cfg_wdata,
    output logic             done,
    output out_beat_t        result
);

    logic [RateW-1:0] rate_reg;
    logic take, push, pop, empty, almost_full, idle;
    logic frame_open_reg;
    job_t job, head;

    assign take = start && !busy;
    // Hold input off from a frame end until its result is out.
    assign busy = almost_full || frame_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RateReset;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                rate_reg <= cfg_wdata;
            if (take && in_beat.last_bin)
                frame_open_reg <= 1'b1;
            else if (done)
                frame_open_reg <= 1'b0;
        end
    end

    cctm_front #(.BIN_COUNT(BIN_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .beat(in_beat), .push(push), .job(job)
    );

    cctm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(job), .pop(pop),
        .empty(empty), .almost_full(almost_full), .head(head)
    );

    cctm_back #(.BIN_COUNT(BIN_COUNT), .OCTAVE_COUNT(OCTAVE_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .sample_rate(rate_reg), .empty(empty), .head(head),
        .pop(pop), .idle(idle), .result_valid(done), .result(result)
    );

`ifndef SYNTHESIS
    a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.chord_found |-> result.best_score == '0)
        else $error("no-chord result with nonzero score");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !idle)
        else $error("result while back end idle");
`endif

endmodule
